// ----- hdl/plsimp_pkg.sv -----
// Shared constants and types for the polyline simplifier.
// No dependencies; imported by the simplifier top level.
`default_nettype none

package plsimp_pkg;

    localparam int MAX_SAMPLES_DEF = 4096;
    localparam int COORD_BITS_DEF  = 32;
    localparam int FIELD_W         = 32;
    localparam int ORG_W           = 12;
    localparam int TOL_W           = 16;
    localparam int T_FRAC          = 30;
    localparam logic [TOL_W-1:0] TOL_RESET = 16'd128;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_NONE  = 2'd2,
        STAT_OVF   = 2'd3
    } status_t;

endpackage

`default_nettype wire

// ----- hdl/plsimp_ram.sv -----
// Generic single write, single read RAM with registered read data.
// No dependencies.
`default_nettype none

module plsimp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- hdl/plsimp_mul.sv -----
// Shift-add unsigned multiplier, one partial product per cycle.
// No dependencies; used by the simplifier sequencer.
`default_nettype none

module plsimp_mul #(
    parameter int MW = 34
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire logic [MW-1:0]   a,
    input  wire logic [MW-1:0]   b,
    output logic                 done,
    output logic [2*MW-1:0]      prod
);

    localparam int PW  = 2 * MW;
    localparam int CTW = $clog2(MW + 1);

    logic           busy_reg;
    logic           done_reg;
    logic [CTW-1:0] cnt_reg;
    logic [PW-1:0]  acc_reg;
    logic [PW-1:0]  mcand_reg;
    logic [MW-1:0]  mplier_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CTW'(MW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CTW'(1);
            if (cnt_reg == CTW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg    <= '0;
            mcand_reg  <= PW'(a);
            mplier_reg <= b;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
            begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg  <= mcand_reg << 1;
            mplier_reg <= mplier_reg >> 1;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

`default_nettype wire

// ----- hdl/plsimp_div.sv -----
// Restoring fractional divider, one quotient bit per cycle.
// No dependencies; dividend must be below divisor.
`default_nettype none

module plsimp_div #(
    parameter int W     = 67,
    parameter int STEPS = 30
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [W-1:0]     dividend,
    input  wire logic [W-1:0]     divisor,
    output logic                  done,
    output logic [STEPS-1:0]      quot
);

    localparam int CTW = $clog2(STEPS + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CTW-1:0]   cnt_reg;
    logic [W:0]       rem_reg;
    logic [W-1:0]     dvs_reg;
    logic [STEPS-1:0] q_reg;
    logic [W:0]       shifted;
    logic             ge;

    assign shifted = rem_reg << 1;
    assign ge      = shifted >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CTW'(STEPS);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CTW'(1);
            if (cnt_reg == CTW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {1'b0, dividend};
            dvs_reg <= divisor;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? (shifted - {1'b0, dvs_reg}) : shifted;
            q_reg   <= {q_reg[STEPS-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

`default_nettype wire

// ----- hdl/polyline_simplifier_top.sv -----
// Polyline simplifier top level: sample store, span-stack sequencer, readout.
// Depends on plsimp_pkg, plsimp_ram, plsimp_mul, plsimp_div.
//
//  channel  | dir | tdata                       | tuser                  | tlast
//  s_       | in  | [31:0] north, [63:32] east  | [0] operation [1] fin. | track_end
//  m_       | out | [11:0] sample_index         | [1:0] status           | final_index
//  cfg_     | in  | cfg_data: tolerance         | -                      | -
//
// Pushes may follow every cycle while s_tready is high.
// A track end with samples stored and no overflow starts simplification, span by
// span and inner point by inner point, on the shared multiplier and divider.
// A pull scans the keep marks entry by entry (SC_ISSUE, SC_CHK), one port of the mark RAM.
// Reset clears counts and flags; marks are cleared as samples are written.
// s_tready is low while simplifying or scanning, and for a pull while a result waits.
`default_nettype none

module polyline_simplifier_top #(
    parameter int MAX_SAMPLES = plsimp_pkg::MAX_SAMPLES_DEF,
    parameter int COORD_BITS  = plsimp_pkg::COORD_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [plsimp_pkg::TOL_W-1:0]        cfg_data,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [2*plsimp_pkg::FIELD_W-1:0]    s_tdata,  // north_pos, east_pos
    input  wire logic [1:0]                          s_tuser,  // operation, coords_finite
    input  wire logic                                s_tlast,  // track_end
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [15:0]                              m_tdata,  // sample_index, zero pad
    output logic [1:0]                               m_tuser,  // status
    output logic                                     m_tlast   // final_index
);

    import plsimp_pkg::*;

    localparam int CW    = COORD_BITS;
    localparam int DW    = CW + 1;
    localparam int RWD   = CW + 3;
    localparam int TW    = T_FRAC + 1;
    localparam int MW    = (CW + 2 > TW) ? CW + 2 : TW;
    localparam int PW    = 2 * MW;
    localparam int SW    = 2 * CW + 3;
    localparam int IDX_W = $clog2(MAX_SAMPLES);
    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

    typedef enum logic [17:0] {
        ST_IDLE     = 18'h00001,
        ST_MARK0    = 18'h00002,
        ST_MARKL    = 18'h00004,
        ST_POP      = 18'h00008,
        ST_SPAN_RD  = 18'h00010,
        ST_A_RD     = 18'h00020,
        ST_B_RD     = 18'h00040,
        ST_MUL_GO   = 18'h00080,
        ST_MUL_WAIT = 18'h00100,
        ST_PT_ISSUE = 18'h00200,
        ST_PT_RD    = 18'h00400,
        ST_DOT      = 18'h00800,
        ST_DIV_WAIT = 18'h01000,
        ST_CMP      = 18'h02000,
        ST_SPAN_END = 18'h04000,
        ST_PUSH2    = 18'h08000,
        ST_SC_ISSUE = 18'h10000,
        ST_SC_CHK   = 18'h20000
    } state_t;

    typedef enum logic [2:0] {
        MS_LEN_N = 3'd0,
        MS_LEN_E = 3'd1,
        MS_T1    = 3'd2,
        MS_T2    = 3'd3,
        MS_QN    = 3'd4,
        MS_QE    = 3'd5,
        MS_RN    = 3'd6,
        MS_RE    = 3'd7
    } mstep_t;

    state_t state_reg, state_next;
    mstep_t mstep_reg, mstep_next;

    logic [TOL_W-1:0] tol_reg;
    logic [CNT_W-1:0] rc_reg, rc_next, fc_reg, fc_next, rptr_reg, rptr_next;
    logic             ovf_reg, ovf_next, closed_reg, closed_next, rdone_reg, rdone_next;
    logic [CNT_W-1:0] depth_reg, depth_next;
    logic [CNT_W-1:0] scan_ptr_reg, scan_ptr_next, here_ptr_reg, here_ptr_next;
    logic             found_reg, found_next;
    logic [ORG_W-1:0] here_org_reg, here_org_next;

    logic [IDX_W-1:0] first_reg, first_next, last_reg, last_next;
    logic [IDX_W-1:0] k_reg, k_next, far_reg, far_next;
    logic signed [CW-1:0]  na_reg, na_next, ea_reg, ea_next;
    logic signed [DW-1:0]  dn_reg, dn_next, de_reg, de_next, n_reg, n_next, e_reg, e_next;
    logic signed [RWD-1:0] rn_reg, rn_next, re_reg, re_next;
    logic [SW-1:0] len2_reg, len2_next, t1_reg, t1_next, t2_reg, t2_next;
    logic [SW-1:0] d_reg, d_next, best_reg, best_next;
    logic [TW-1:0] t_reg, t_next;

    logic             out_valid_reg, out_valid_next, out_last_reg, out_last_next;
    logic [ORG_W-1:0] out_idx_reg, out_idx_next;
    status_t          out_stat_reg, out_stat_next;

    logic             crd_we, keep_we, keep_wdata, stk_we;
    logic [IDX_W-1:0] crd_waddr, crd_raddr, keep_waddr, stk_waddr, stk_raddr, scan_addr;
    logic [CW-1:0]    n_rd, e_rd;
    logic [ORG_W-1:0] org_wdata, org_rd;
    logic             keep_rd;
    logic [2*IDX_W-1:0] stk_wdata, stk_rd;

    logic          mul_start, mul_done, div_start, div_done;
    logic [MW-1:0] mul_a, mul_b;
    logic [PW-1:0] mul_prod;
    logic [T_FRAC-1:0] div_q;

    logic [DW-1:0]  mag_dn, mag_de, mag_n, mag_e;
    logic [RWD-1:0] mag_rn, mag_re;
    logic [SW-1:0]  pos_sum, neg_sum, dot;
    logic [PW-1:0]  qsum;
    logic [DW-1:0]  qv;
    logic           out_free, accept, op_pull;
    logic [CNT_W-1:0] rc_eff, fc_eff;

    assign mag_dn = dn_reg[DW-1] ? DW'(-dn_reg) : DW'(dn_reg);
    assign mag_de = de_reg[DW-1] ? DW'(-de_reg) : DW'(de_reg);
    assign mag_n  = n_reg[DW-1] ? DW'(-n_reg) : DW'(n_reg);
    assign mag_e  = e_reg[DW-1] ? DW'(-e_reg) : DW'(e_reg);
    assign mag_rn = rn_reg[RWD-1] ? RWD'(-rn_reg) : RWD'(rn_reg);
    assign mag_re = re_reg[RWD-1] ? RWD'(-re_reg) : RWD'(re_reg);

    assign pos_sum = ((n_reg[DW-1] != dn_reg[DW-1]) ? '0 : t1_reg)
                   + ((e_reg[DW-1] != de_reg[DW-1]) ? '0 : t2_reg);
    assign neg_sum = ((n_reg[DW-1] != dn_reg[DW-1]) ? t1_reg : '0)
                   + ((e_reg[DW-1] != de_reg[DW-1]) ? t2_reg : '0);
    assign dot     = pos_sum - neg_sum;
    assign qsum    = mul_prod + (PW'(1) << (T_FRAC - 1));
    assign qv      = DW'(qsum >> T_FRAC);

    assign out_free = !out_valid_reg || m_tready;
    assign op_pull  = s_tuser[0];
    assign s_tready = (state_reg == ST_IDLE) && (!op_pull || out_free);
    assign accept   = s_tvalid && s_tready;
    assign rc_eff   = closed_reg ? '0 : rc_reg;
    assign fc_eff   = closed_reg ? '0 : fc_reg;
    assign scan_addr = scan_ptr_reg[IDX_W-1:0];

    assign crd_we    = accept && !op_pull && s_tuser[1] && (rc_eff < CNT_W'(MAX_SAMPLES));
    assign crd_waddr = fc_eff[IDX_W-1:0];
    assign org_wdata = ORG_W'(rc_eff);

    always_comb
    begin
        case (mstep_reg)
            MS_LEN_N: begin mul_a = MW'(mag_dn); mul_b = MW'(mag_dn); end
            MS_LEN_E: begin mul_a = MW'(mag_de); mul_b = MW'(mag_de); end
            MS_T1:    begin mul_a = MW'(mag_n);  mul_b = MW'(mag_dn); end
            MS_T2:    begin mul_a = MW'(mag_e);  mul_b = MW'(mag_de); end
            MS_QN:    begin mul_a = MW'(t_reg);  mul_b = MW'(mag_dn); end
            MS_QE:    begin mul_a = MW'(t_reg);  mul_b = MW'(mag_de); end
            MS_RN:    begin mul_a = MW'(mag_rn); mul_b = MW'(mag_rn); end
            MS_RE:    begin mul_a = MW'(mag_re); mul_b = MW'(mag_re); end
            default:  begin mul_a = '0; mul_b = '0; end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        mstep_next     = mstep_reg;
        rc_next        = rc_reg;
        fc_next        = fc_reg;
        rptr_next      = rptr_reg;
        ovf_next       = ovf_reg;
        closed_next    = closed_reg;
        rdone_next     = rdone_reg;
        depth_next     = depth_reg;
        scan_ptr_next  = scan_ptr_reg;
        here_ptr_next  = here_ptr_reg;
        found_next     = found_reg;
        here_org_next  = here_org_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        k_next         = k_reg;
        far_next       = far_reg;
        na_next        = na_reg;
        ea_next        = ea_reg;
        dn_next        = dn_reg;
        de_next        = de_reg;
        n_next         = n_reg;
        e_next         = e_reg;
        rn_next        = rn_reg;
        re_next        = re_reg;
        len2_next      = len2_reg;
        t1_next        = t1_reg;
        t2_next        = t2_reg;
        d_next         = d_reg;
        best_next      = best_reg;
        t_next         = t_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_last_next  = out_last_reg;
        out_idx_next   = out_idx_reg;
        out_stat_next  = out_stat_reg;
        keep_we        = 1'b0;
        keep_waddr     = fc_eff[IDX_W-1:0];
        keep_wdata     = 1'b0;
        stk_we         = 1'b0;
        stk_waddr      = depth_reg[IDX_W-1:0];
        stk_wdata      = {first_reg, far_reg};
        stk_raddr      = IDX_W'(depth_reg - CNT_W'(1));
        crd_raddr      = k_reg;
        mul_start      = 1'b0;
        div_start      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && !op_pull)
                begin
                    rc_next = rc_eff;
                    fc_next = fc_eff;
                    if (closed_reg)
                    begin
                        ovf_next   = 1'b0;
                        rptr_next  = '0;
                        rdone_next = 1'b0;
                    end
                    if (rc_eff >= CNT_W'(MAX_SAMPLES))
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        if (s_tuser[1])
                        begin
                            keep_we = 1'b1;
                            fc_next = fc_eff + CNT_W'(1);
                        end
                        rc_next = rc_eff + CNT_W'(1);
                    end
                    closed_next = s_tlast;
                    if (s_tlast && !ovf_next && fc_next != '0)
                    begin
                        state_next = ST_MARK0;
                    end
                end
                else if (accept)
                begin
                    out_valid_next = 1'b1;
                    out_idx_next   = '0;
                    out_last_next  = 1'b0;
                    out_stat_next  = STAT_NONE;
                    if (closed_reg && !rdone_reg)
                    begin
                        if (ovf_reg || fc_reg == '0)
                        begin
                            out_stat_next = ovf_reg ? STAT_OVF : STAT_EMPTY;
                            rdone_next    = 1'b1;
                        end
                        else
                        begin
                            out_valid_next = 1'b0;
                            scan_ptr_next  = rptr_reg;
                            found_next     = 1'b0;
                            state_next     = ST_SC_ISSUE;
                        end
                    end
                end
            end
            ST_MARK0:
            begin
                keep_we    = 1'b1;
                keep_waddr = '0;
                keep_wdata = 1'b1;
                state_next = ST_MARKL;
            end
            ST_MARKL:
            begin
                keep_we    = 1'b1;
                keep_waddr = IDX_W'(fc_reg - CNT_W'(1));
                keep_wdata = 1'b1;
                if (fc_reg <= CNT_W'(2))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    stk_we     = 1'b1;
                    stk_waddr  = '0;
                    stk_wdata  = {IDX_W'(0), IDX_W'(fc_reg - CNT_W'(1))};
                    depth_next = CNT_W'(1);
                    state_next = ST_POP;
                end
            end
            ST_POP:
            begin
                if (depth_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    depth_next = depth_reg - CNT_W'(1);
                    state_next = ST_SPAN_RD;
                end
            end
            ST_SPAN_RD:
            begin
                first_next = stk_rd[2*IDX_W-1:IDX_W];
                last_next  = stk_rd[IDX_W-1:0];
                crd_raddr  = stk_rd[2*IDX_W-1:IDX_W];
                state_next = ST_A_RD;
            end
            ST_A_RD:
            begin
                na_next    = $signed(n_rd);
                ea_next    = $signed(e_rd);
                crd_raddr  = last_reg;
                state_next = ST_B_RD;
            end
            ST_B_RD:
            begin
                dn_next    = DW'($signed(n_rd)) - DW'(na_reg);
                de_next    = DW'($signed(e_rd)) - DW'(ea_reg);
                best_next  = SW'(tol_reg * tol_reg);
                far_next   = first_reg;
                k_next     = first_reg + IDX_W'(1);
                mstep_next = MS_LEN_N;
                state_next = ST_MUL_GO;
            end
            ST_MUL_GO:
            begin
                mul_start  = 1'b1;
                state_next = ST_MUL_WAIT;
            end
            ST_MUL_WAIT:
            begin
                if (mul_done)
                begin
                    state_next = ST_MUL_GO;
                    case (mstep_reg)
                        MS_LEN_N:
                        begin
                            len2_next  = SW'(mul_prod);
                            mstep_next = MS_LEN_E;
                        end
                        MS_LEN_E:
                        begin
                            len2_next  = len2_reg + SW'(mul_prod);
                            state_next = ST_PT_ISSUE;
                        end
                        MS_T1:
                        begin
                            t1_next    = SW'(mul_prod);
                            mstep_next = MS_T2;
                        end
                        MS_T2:
                        begin
                            t2_next    = SW'(mul_prod);
                            state_next = ST_DOT;
                        end
                        MS_QN:
                        begin
                            rn_next    = dn_reg[DW-1] ? RWD'(n_reg) + RWD'(qv)
                                                      : RWD'(n_reg) - RWD'(qv);
                            mstep_next = MS_QE;
                        end
                        MS_QE:
                        begin
                            re_next    = de_reg[DW-1] ? RWD'(e_reg) + RWD'(qv)
                                                      : RWD'(e_reg) - RWD'(qv);
                            mstep_next = MS_RN;
                        end
                        MS_RN:
                        begin
                            d_next     = SW'(mul_prod);
                            mstep_next = MS_RE;
                        end
                        MS_RE:
                        begin
                            d_next     = d_reg + SW'(mul_prod);
                            state_next = ST_CMP;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_PT_ISSUE:
            begin
                crd_raddr = k_reg;
                if (k_reg >= last_reg)
                begin
                    state_next = ST_SPAN_END;
                end
                else
                begin
                    state_next = ST_PT_RD;
                end
            end
            ST_PT_RD:
            begin
                n_next     = DW'($signed(n_rd)) - DW'(na_reg);
                e_next     = DW'($signed(e_rd)) - DW'(ea_reg);
                mstep_next = MS_T1;
                state_next = ST_MUL_GO;
            end
            ST_DOT:
            begin
                mstep_next = MS_QN;
                state_next = ST_MUL_GO;
                t_next     = '0;
                if (len2_reg != '0 && pos_sum > neg_sum)
                begin
                    if (dot >= len2_reg)
                    begin
                        t_next = TW'(1) << T_FRAC;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV_WAIT;
                    end
                end
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    t_next     = TW'(div_q);
                    state_next = ST_MUL_GO;
                end
            end
            ST_CMP:
            begin
                if (d_reg > best_reg)
                begin
                    best_next = d_reg;
                    far_next  = k_reg;
                end
                k_next     = k_reg + IDX_W'(1);
                state_next = ST_PT_ISSUE;
            end
            ST_SPAN_END:
            begin
                state_next = ST_POP;
                if (far_reg != first_reg)
                begin
                    keep_we    = 1'b1;
                    keep_waddr = far_reg;
                    keep_wdata = 1'b1;
                    if (depth_reg < CNT_W'(MAX_SAMPLES))
                    begin
                        stk_we     = 1'b1;
                        stk_wdata  = {first_reg, far_reg};
                        depth_next = depth_reg + CNT_W'(1);
                    end
                    state_next = ST_PUSH2;
                end
            end
            ST_PUSH2:
            begin
                if (depth_reg < CNT_W'(MAX_SAMPLES))
                begin
                    stk_we     = 1'b1;
                    stk_wdata  = {far_reg, last_reg};
                    depth_next = depth_reg + CNT_W'(1);
                end
                state_next = ST_POP;
            end
            ST_SC_ISSUE:
            begin
                if (scan_ptr_reg >= fc_reg)
                begin
                    out_valid_next = 1'b1;
                    out_idx_next   = found_reg ? here_org_reg : '0;
                    out_last_next  = found_reg;
                    out_stat_next  = found_reg ? STAT_OK : STAT_NONE;
                    rptr_next      = found_reg ? here_ptr_reg + CNT_W'(1) : rptr_reg;
                    rdone_next     = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    state_next = ST_SC_CHK;
                end
            end
            ST_SC_CHK:
            begin
                scan_ptr_next = scan_ptr_reg + CNT_W'(1);
                state_next    = ST_SC_ISSUE;
                if (keep_rd)
                begin
                    if (!found_reg)
                    begin
                        found_next    = 1'b1;
                        here_ptr_next = scan_ptr_reg;
                        here_org_next = org_rd;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        out_idx_next   = here_org_reg;
                        out_last_next  = 1'b0;
                        out_stat_next  = STAT_OK;
                        rptr_next      = here_ptr_reg + CNT_W'(1);
                        state_next     = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mstep_reg     <= MS_LEN_N;
            tol_reg       <= TOL_RESET;
            rc_reg        <= '0;
            fc_reg        <= '0;
            rptr_reg      <= '0;
            ovf_reg       <= 1'b0;
            closed_reg    <= 1'b0;
            rdone_reg     <= 1'b0;
            depth_reg     <= '0;
            scan_ptr_reg  <= '0;
            here_ptr_reg  <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mstep_reg     <= mstep_next;
            if (cfg_we)
            begin
                tol_reg <= cfg_data;
            end
            rc_reg        <= rc_next;
            fc_reg        <= fc_next;
            rptr_reg      <= rptr_next;
            ovf_reg       <= ovf_next;
            closed_reg    <= closed_next;
            rdone_reg     <= rdone_next;
            depth_reg     <= depth_next;
            scan_ptr_reg  <= scan_ptr_next;
            here_ptr_reg  <= here_ptr_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        here_org_reg <= here_org_next;
        first_reg    <= first_next;
        last_reg     <= last_next;
        k_reg        <= k_next;
        far_reg      <= far_next;
        na_reg       <= na_next;
        ea_reg       <= ea_next;
        dn_reg       <= dn_next;
        de_reg       <= de_next;
        n_reg        <= n_next;
        e_reg        <= e_next;
        rn_reg       <= rn_next;
        re_reg       <= re_next;
        len2_reg     <= len2_next;
        t1_reg       <= t1_next;
        t2_reg       <= t2_next;
        d_reg        <= d_next;
        best_reg     <= best_next;
        t_reg        <= t_next;
        out_last_reg <= out_last_next;
        out_idx_reg  <= out_idx_next;
        out_stat_reg <= out_stat_next;
    end

    plsimp_ram #(.WIDTH(CW), .DEPTH(MAX_SAMPLES)) u_north (
        .clk(clk), .we(crd_we), .waddr(crd_waddr), .wdata(s_tdata[CW-1:0]),
        .raddr(crd_raddr), .rdata(n_rd)
    );

    plsimp_ram #(.WIDTH(CW), .DEPTH(MAX_SAMPLES)) u_east (
        .clk(clk), .we(crd_we), .waddr(crd_waddr),
        .wdata(s_tdata[FIELD_W+CW-1:FIELD_W]), .raddr(crd_raddr), .rdata(e_rd)
    );

    plsimp_ram #(.WIDTH(ORG_W), .DEPTH(MAX_SAMPLES)) u_origin (
        .clk(clk), .we(crd_we), .waddr(crd_waddr), .wdata(org_wdata),
        .raddr(scan_addr), .rdata(org_rd)
    );

    plsimp_ram #(.WIDTH(1), .DEPTH(MAX_SAMPLES)) u_keep (
        .clk(clk), .we(keep_we), .waddr(keep_waddr), .wdata(keep_wdata),
        .raddr(scan_addr), .rdata(keep_rd)
    );

    plsimp_ram #(.WIDTH(2*IDX_W), .DEPTH(MAX_SAMPLES)) u_stack (
        .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
        .raddr(stk_raddr), .rdata(stk_rd)
    );

    plsimp_mul #(.MW(MW)) u_mul (
        .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b),
        .done(mul_done), .prod(mul_prod)
    );

    plsimp_div #(.W(SW), .STEPS(T_FRAC)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(dot),
        .divisor(len2_reg), .done(div_done), .quot(div_q)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = 16'(out_idx_reg);
    assign m_tuser  = out_stat_reg;
    assign m_tlast  = out_last_reg;

    a_mul_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> state_reg == ST_MUL_WAIT)
        else $error("multiplier finished outside its wait state");

    a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV_WAIT)
        else $error("divider finished outside its wait state");

    a_status_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != STAT_OK) |-> (m_tdata == '0 && !m_tlast))
        else $error("status result carries an index");

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= CNT_W'(MAX_SAMPLES))
        else $error("span stack depth out of range");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SC_CHK) |-> (scan_ptr_reg < fc_reg))
        else $error("keep scan past the stored samples");

endmodule

`default_nettype wire
